### rtl/sha_pkg.sv
// Package for the SHA-256 stream hasher: round constants, initial hash values,
// state encoding and helper functions. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage

### rtl/sha_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read-first: a read of the address being written returns the old data; read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### rtl/sha_round.sv
// SHA-256 round datapath: message schedule window and working variables.
// Depends on sha_pkg.
module sha_round import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        init_i,     // load working variables from chain
  input  logic [31:0] chain_i [8],
  input  logic        shift_i,    // shift one byte into the schedule window
  input  logic [7:0]  byte_i,
  input  logic        step_i,     // run one round
  input  logic [5:0]  round_i,
  output logic [31:0] vars_o [8]
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] w_new, w_cur, s0, s1, sig0, sig1, ch, maj, t1, t2;

  // Schedule: the first 16 rounds use the loaded words, later ones the expansion.
  always_comb begin
    s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
    s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    w_cur = w_q[0];
    sig1 = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + sig1 + ch + ROUND_K[round_i] + w_cur;
    sig0 = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2 = sig0 + maj;
  end

  // Window of 16 words; during loading bytes enter big-endian at the tail.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[15] <= {w_q[15][23:0], byte_i};
    end else if (step_i) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  // Working variables a..h.
  always_ff @(posedge clk_i) begin
    if (init_i) begin
      v_q <= chain_i;
    end else if (step_i) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign vars_o = v_q;

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: control, byte count, block buffer.
// Depends on sha_pkg, sha_ram and sha_round.
//
// An append beat stores the byte in a 64x8 block RAM.
// The 64th byte starts a block pass. First, the RAM is read into the schedule
// window, one byte per cycle through the single RAM port, whose read data is
// registered. Then come the 64 rounds and a fold step. A finish beat writes
// the pad bytes into the RAM, one per cycle. This is 9 to 72 bytes, so one
// or two block passes follow. The block then offers the eight digest words,
// index 0 first, with tlast on the eighth. No input is taken while a block
// pass, padding or the digest output is in progress.
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
  output logic        m_axis_tlast    // last_word
);

  state_e state_q, state_d;
  logic [63:0] count_q, count_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        fin_q, fin_d;         // a finish is in progress
  logic        mark_q, mark_d;       // pad mark already written
  logic        len_blk_q, len_blk_d; // the current pad block carries the length
  logic [6:0]  step_q, step_d;       // load/round step counter
  logic [2:0]  widx_q, widx_d;
  logic [31:0] chain_q [8];
  logic [31:0] vars [8];

  logic       ram_we;
  logic [5:0] ram_addr;
  logic [7:0] ram_wdata, ram_rdata;
  logic       in_fire, out_fire;
  logic       rnd_init, rnd_shift, rnd_step;
  logic [7:0] pad_byte;
  logic [5:0] pos;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign pos      = count_q[5:0];

  sha_ram #(.Width(8), .Depth(64)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  sha_round u_round (
    .clk_i   (clk_i),
    .init_i  (rnd_init),
    .chain_i (chain_q),
    .shift_i (rnd_shift),
    .byte_i  (ram_rdata),
    .step_i  (rnd_step),
    .round_i (step_q[5:0]),
    .vars_o  (vars)
  );

  // Pad byte for the current position: mark first, then zeros, and the
  // big-endian length in the last eight bytes of the block that has room.
  always_comb begin
    if (!mark_q) begin
      pad_byte = PAD_MARK;
    end else if (len_blk_q && pos >= LEN_OFFSET) begin
      pad_byte = bitlen_q[{~pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && s_axis_tuser == CMD_FINISH) begin
          state_d = ST_PAD;
        end else if (in_fire && pos == 6'd63) begin
          state_d = ST_LOAD;
        end
      end
      ST_PAD:   if (pos == 6'd63) state_d = ST_LOAD;
      ST_LOAD:  if (step_q == 7'd64) state_d = ST_ROUND;
      ST_ROUND: if (step_q == 7'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        if (!fin_q) state_d = ST_IDLE;
        else if (len_blk_q) state_d = ST_EMIT;
        else state_d = ST_PAD;
      end
      ST_EMIT:  if (out_fire && widx_q == 3'd7) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    count_d   = count_q;
    bitlen_d  = bitlen_q;
    fin_d     = fin_q;
    mark_d    = mark_q;
    len_blk_d = len_blk_q;
    step_d    = step_q;
    widx_d    = widx_q;
    ram_we    = 1'b0;
    ram_addr  = pos;
    ram_wdata = s_axis_tdata;
    rnd_init  = 1'b0;
    rnd_shift = 1'b0;
    rnd_step  = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_fire && s_axis_tuser == CMD_APPEND) begin
          ram_we  = 1'b1;
          count_d = count_q + 64'd1;
        end else if (in_fire) begin
          bitlen_d  = {count_q[60:0], 3'b000};
          fin_d     = 1'b1;
          mark_d    = 1'b0;
          len_blk_d = 1'b0;
        end
      end
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = pad_byte;
        count_d   = count_q + 64'd1;
        step_d    = '0;
        // The length fits behind the mark only if the mark lands before offset 56.
        if (!mark_q) begin
          mark_d    = 1'b1;
          len_blk_d = (pos < LEN_OFFSET);
        end
      end
      ST_LOAD: begin
        ram_addr  = step_q[5:0];
        rnd_shift = (step_q != 7'd0);
        rnd_init  = 1'b1;
        step_d    = (step_q == 7'd64) ? 7'd0 : step_q + 7'd1;
      end
      ST_ROUND: begin
        rnd_step = 1'b1;
        step_d   = step_q + 7'd1;
      end
      ST_FOLD: begin
        step_d = '0;
        // A pad block without the length is followed by one that has it.
        if (fin_q && !len_blk_q) begin
          len_blk_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            count_d   = '0;
            fin_d     = 1'b0;
            mark_d    = 1'b0;
            len_blk_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers; the chain is folded after each pass and restarted after
  // the last digest beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      bitlen_q  <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_blk_q <= 1'b0;
      step_q    <= '0;
      widx_q    <= '0;
      for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      bitlen_q  <= bitlen_d;
      fin_q     <= fin_d;
      mark_q    <= mark_d;
      len_blk_q <= len_blk_d;
      step_q    <= step_d;
      widx_q    <= widx_d;
      if (state_q == ST_FOLD) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars[i];
      end
      if (state_q == ST_EMIT && out_fire && widx_q == 3'd7) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= INIT_HASH[i];
      end
    end
  end

  // Digest words are offered straight from the chaining registers.
  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {5'd0, widx_q, chain_q[widx_q]};
  assign m_axis_tlast  = (widx_q == 3'd7);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted during digest output");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (step_q < 7'd64))
    else $error("round counter out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(widx_q))
    else $error("digest index moved while stalled");
`endif

endmodule

### test/tb.sv
// Testbench for sha256_stream_hasher: directed and random byte messages with finish beats,
// checked against an in-bench SHA-256 digest predictor. Depends on sha_pkg.
`timescale 1ns / 1ps

module tb;
  import sha_pkg::*;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  msg_beat_t    pending_beats[$];
  digest_beat_t expected_digest[$];
  int           error_count = 0;
  bit           stim_done = 1'b0;
  bit           hold_off = 1'b0;

  // Predictor state.
  logic [31:0] hash_words[8];
  logic [7:0]  msg_block[64];
  logic [63:0] msg_bytes;

  sha256_stream_hasher u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of msg_block into hash_words.
  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    msg_block[msg_bytes[5:0]] = b;
    msg_bytes++;
    if (msg_bytes[5:0] == 6'd0) compress_block();
  endtask

  // Apply one accepted beat; a finish pads and queues the eight digest words.
  task automatic predict_digest(msg_beat_t beat);
    logic [63:0] bit_len;
    if (beat.cmd == CMD_APPEND) begin
      absorb_byte(beat.data);
    end else begin
      bit_len = msg_bytes << 3;
      absorb_byte(PAD_MARK);
      while (msg_bytes[5:0] != LEN_OFFSET) absorb_byte(8'h00);
      for (int i = 7; i >= 0; i--) absorb_byte(bit_len[8*i +: 8]);
      for (int i = 0; i < 8; i++)
        expected_digest.push_back('{hash_words[i], 3'(i), i == 7});
      for (int i = 0; i < 8; i++) hash_words[i] = INIT_HASH[i];
      msg_bytes = '0;
    end
  endtask

  task automatic add_message(int len, bit rand_data);
    for (int i = 0; i < len; i++)
      pending_beats.push_back('{CMD_APPEND, rand_data ? 8'($urandom) : 8'(i)});
    pending_beats.push_back('{CMD_FINISH, 8'($urandom)});
  endtask

  // Sender: random gap before each beat, valid held until accepted.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digest('{s_axis_tuser, s_axis_tdata});
        void'(pending_beats.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_beats[0].cmd;
        s_axis_tdata  <= pending_beats[0].data;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks each digest beat, then draws a random stall.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: expected no digest beat, got %h", $time, m_axis_tdata);
          error_count++;
        end else begin
          want = expected_digest.pop_front();
          if (m_axis_tdata[31:0] !== want.word || m_axis_tdata[34:32] !== want.index
              || m_axis_tlast !== want.last) begin
            $display("%0t: expected word %h index %0d last %b, got %h %0d %b", $time,
                     want.word, want.index, want.last, m_axis_tdata[31:0],
                     m_axis_tdata[34:32], m_axis_tlast);
            error_count++;
          end
        end
        recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
      end
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b1 ^ 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Long receiver stall; the DUT takes no bytes while a digest waits on it.
  initial begin
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (600) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    for (int i = 0; i < 8; i++) hash_words[i] = INIT_HASH[i];
    msg_bytes = '0;
    // Directed: empty message, back-to-back finishes, short messages.
    add_message(0, 0);
    add_message(0, 0);
    add_message(1, 0);
    pending_beats[$] = '{CMD_FINISH, 8'hff};
    pending_beats.push_back('{CMD_APPEND, 8'hff});
    pending_beats.push_back('{CMD_APPEND, 8'h00});
    pending_beats.push_back('{CMD_FINISH, 8'h00});
    add_message(3, 1);
    // A full data block, then the mark at offset 56 so the length needs a
    // second pad block.
    add_message(120, 1);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_beats.size() == 0 && expected_digest.size() == 0);
    repeat (300) @(posedge clk_i);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (error_count == 0 && expected_digest.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

endmodule
